// ===== rtl/ascii_word_machine_executor_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII word machine executor
// Shared helpers so each check is written on one line.
// ----------------------------------------------------------------------------
`ifndef ASCII_WORD_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define ASCII_WORD_MACHINE_EXECUTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define AWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define AWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/awm_pkg.sv =====
// ----------------------------------------------------------------------------
// awm_pkg
// Types and constants of the ASCII word machine executor.
// ----------------------------------------------------------------------------
package awm_pkg;

  localparam int PC_W = 7;

  // request kinds on the input tuser field
  typedef enum logic [1:0] {
    REQ_JOB  = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_STEP = 2'd2,
    REQ_DATA = 2'd3
  } req_t;

  // result status codes on the output tuser field
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OUTWORD = 3'd1,
    ST_AWAIT   = 3'd2,
    ST_HALT    = 3'd3,
    ST_END     = 3'd4,
    ST_REJECT  = 3'd5,
    ST_BADOP   = 3'd6
  } status_t;

  // characters used by the decoder
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  // reciprocal of ten, scaled by 2^19, exact for values below 43690
  localparam logic [15:0] RECIP10   = 16'd52429;
  localparam int          RECIP_SH  = 19;

endpackage

// ===== rtl/ascii_word_machine_executor_top.sv =====
// ----------------------------------------------------------------------------
// ascii_word_machine_executor_top
// Small teaching machine: word memory, one register, a toggle and a
// sequencer that runs one instruction per step beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_      in   tvalid/tready    tuser=req_type, tdata=word, tlast=data_last
//  out_     out  tvalid/tready    tuser=status, tdata=word/mask/pc, tlast=last
//
//  Load, data and job reset beats go from S_IDLE to S_OUT for the handshake.
//  A step runs S_FETCH and S_DEC; LR, CR and AD add an operand read; AD then
//  parses, splits digits and packs, with separate multipliers. PD sends one
//  block word per output beat. All reads share the single memory read port.
//  rst_n is synchronous; job reset clears memory through per-word valid bits.
//  in_tready is low while an item is in work or a beat waits on out_tready.
// ----------------------------------------------------------------------------
module ascii_word_machine_executor_top #(
  parameter int MEM_WORDS   = 100,
  parameter int BLOCK_WORDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] word
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic        in_tlast,   // data_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] out_word, [35:32] byte_valid, [42:36] pc
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last
);
  import awm_pkg::*;

  `include "ascii_word_machine_executor_top_defines.svh"

  localparam int         AW    = $clog2(MEM_WORDS);
  localparam logic [7:0] MEM8  = 8'(MEM_WORDS);
  localparam logic [7:0] BLK8  = 8'(BLOCK_WORDS);
  localparam logic [3:0] BLK4  = 4'(BLOCK_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DEC, S_OPRD, S_PARSE, S_PEND, S_FMT, S_PACK,
    S_PDRD, S_PDOUT, S_OUT
  } state_t;

  typedef enum logic [1:0] {P_LEAD, P_DIG, P_STOP} phase_t;

  state_t state_r;

  // architectural state
  logic [31:0]     gr_r;
  logic            tog_r, open_r, await_r;
  logic [PC_W-1:0] pc_r, lp_r, dp_r;
  logic [3:0]      dcnt_r;

  // word memory with per-word valid bits
  logic [31:0]          mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [31:0]          rdata_r;
  logic                 rvld_r;
  logic [31:0]          rd_q;
  logic                 we;
  logic [AW-1:0]        wa, ra;
  logic [31:0]          wd;

  // instruction and PD sequencing
  logic [31:0]     ir_r;
  logic [PC_W-1:0] blk_r;
  logic [3:0]      k_r;
  logic [PC_W-1:0] pda;

  // parse unit
  logic [31:0] psh_r, opb_r;
  logic [1:0]  pcnt_r;
  phase_t      ph_r;
  logic        pi_r, neg_r, nd_r;
  logic [13:0] acc_r;
  logic signed [15:0] a_r;

  // format unit
  logic [14:0] fm_r;
  logic        fneg_r;
  logic [2:0]  nr_r;
  logic [3:0]  rev_r [5];

  // output beat
  status_t     ost_r;
  logic        opd_r, olast_r;
  logic [31:0] oword_r;
  logic [3:0]  omask_r;

  // input accept
  logic  in_acc;
  req_t  req;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign req       = req_t'(in_tuser);

  // instruction decode
  logic [7:0]      c0, c1, b2, b3;
  logic            d2ok, d3ok, blk_bad, addr_bad, is_gp, is_lscba;
  logic [PC_W-1:0] blk, addr;
  always_comb begin
    c0 = ir_r[31:24];
    c1 = ir_r[23:16];
    b2 = ir_r[15:8];
    b3 = ir_r[7:0];
    d2ok = (b2 >= CH_ZERO) && (b2 <= CH_NINE);
    d3ok = (b3 >= CH_ZERO) && (b3 <= CH_NINE);
    blk  = 7'({3'b000, b2[3:0]} * 7'd10);
    addr = blk + {3'b000, b3[3:0]};
    blk_bad  = !d2ok || (({1'b0, blk} + BLK8) > MEM8);
    addr_bad = !d2ok || !d3ok || ({1'b0, addr} >= MEM8);
    is_gp    = ((c0 == CH_G) || (c0 == CH_P)) && (c1 == CH_D);
    is_lscba = ((c0 == CH_L || c0 == CH_S || c0 == CH_C) && c1 == CH_R) ||
               (c0 == CH_B && c1 == CH_T) || (c0 == CH_A && c1 == CH_D);
  end

  // load word with bytes after the first H forced to zero
  logic [31:0] cutw;
  always_comb begin
    cutw = in_tdata;
    if (in_tdata[31:24] == CH_H) begin
      cutw[23:0] = '0;
    end else if (in_tdata[23:16] == CH_H) begin
      cutw[15:0] = '0;
    end else if (in_tdata[15:8] == CH_H) begin
      cutw[7:0] = '0;
    end
  end

  // memory write and read address selection
  always_comb begin
    pda = blk_r + {3'b000, k_r};
    we = 1'b0;
    wa = lp_r[AW-1:0];
    wd = cutw;
    ra = pc_r[AW-1:0];
    if (in_acc && req == REQ_LOAD && {1'b0, lp_r} < MEM8) begin
      we = 1'b1;
    end else if (in_acc && req == REQ_DATA && await_r && {1'b0, dp_r} < MEM8) begin
      we = 1'b1;
      wa = dp_r[AW-1:0];
      wd = in_tdata;
    end else if (state_r == S_DEC && !is_gp && c0 == CH_S && is_lscba && !addr_bad) begin
      we = 1'b1;
      wa = addr[AW-1:0];
      wd = gr_r;
    end
    if (state_r == S_DEC) begin
      ra = addr[AW-1:0];
    end else if (state_r == S_PDRD) begin
      ra = pda[AW-1:0];
    end
  end

  // word memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  // valid bits stand in for the clear on reset and job reset
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && req == REQ_JOB)) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      rvld_r <= vld_r[ra];
    end
  end
  assign rd_q = rvld_r ? rdata_r : 32'd0;

  // parse step: one character per cycle
  logic [7:0]  pch;
  logic        p_sp, p_dig;
  logic [13:0] acc_mul;
  always_comb begin
    pch   = psh_r[31:24];
    p_sp  = (pch == CH_SPACE) || (pch >= 8'h09 && pch <= 8'h0D);
    p_dig = (pch >= CH_ZERO) && (pch <= CH_NINE);
    acc_mul = 14'(acc_r * 14'd10) + {10'd0, pch[3:0]};
  end

  // parsed value and sum
  logic signed [15:0] pval, psum;
  always_comb begin
    pval = neg_r ? -$signed({2'b00, acc_r}) : $signed({2'b00, acc_r});
    psum = a_r + pval;
  end

  // digit split: quotient by reciprocal, remainder by multiply-back
  logic [30:0] fprod;
  logic [14:0] fq;
  logic [3:0]  fdig;
  always_comb begin
    fprod = fm_r * RECIP10;
    fq    = {3'b000, fprod[30:RECIP_SH]};
    fdig  = 4'(fm_r - 15'(fq * 15'd10));
  end

  // text assembly: sign, digits most significant first, space padding
  logic [31:0] ftext;
  logic [2:0]  fj;
  always_comb begin
    ftext = '0;
    fj    = '0;
    for (int i = 0; i < 4; i++) begin
      fj = 3'(i) - {2'b00, fneg_r};
      if (fneg_r && i == 0) begin
        ftext[31-8*i -: 8] = CH_MINUS;
      end else if (fj < nr_r) begin
        ftext[31-8*i -: 8] = CH_ZERO | {4'h0, rev_r[3'(nr_r - 3'd1 - fj)]};
      end else begin
        ftext[31-8*i -: 8] = CH_SPACE;
      end
    end
  end

  // byte mask of the PD word
  logic [3:0] pmask;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pmask[3-i] = (rd_q[31-8*i -: 8] != CH_NUL);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gr_r    <= '0;
      tog_r   <= 1'b1;
      open_r  <= 1'b0;
      await_r <= 1'b0;
      pc_r    <= '0;
      lp_r    <= '0;
      dp_r    <= '0;
      dcnt_r  <= '0;
      opd_r   <= 1'b0;
      ost_r   <= ST_OK;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            opd_r   <= 1'b0;
            ost_r   <= ST_OK;
            state_r <= S_OUT;
            unique case (req)
              REQ_JOB: begin
                gr_r    <= '0;
                tog_r   <= 1'b1;
                open_r  <= 1'b1;
                await_r <= 1'b0;
                pc_r    <= '0;
                lp_r    <= '0;
                dp_r    <= '0;
                dcnt_r  <= '0;
              end
              REQ_LOAD: begin
                if ({1'b0, lp_r} < MEM8) begin
                  lp_r <= lp_r + 7'd1;
                end else begin
                  ost_r <= ST_REJECT;
                end
              end
              REQ_DATA: begin
                if (await_r && {1'b0, dp_r} < MEM8) begin
                  dp_r   <= dp_r + 7'd1;
                  dcnt_r <= dcnt_r + 4'd1;
                  if (in_tlast || (dcnt_r + 4'd1) == BLK4) begin
                    await_r <= 1'b0;
                  end
                end else begin
                  await_r <= 1'b0;
                  ost_r   <= ST_REJECT;
                end
              end
              REQ_STEP: begin
                if (!open_r || await_r) begin
                  ost_r <= ST_REJECT;
                end else if ({1'b0, pc_r} >= MEM8 - 8'd1) begin
                  open_r <= 1'b0;
                  ost_r  <= ST_END;
                end else begin
                  state_r <= S_FETCH;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_FETCH: begin
          if (rd_q[31:24] == CH_NUL) begin
            open_r  <= 1'b0;
            ost_r   <= ST_END;
            state_r <= S_OUT;
          end else begin
            ir_r    <= rd_q;
            pc_r    <= pc_r + 7'd1;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          state_r <= S_OUT;
          if (is_gp) begin
            if (blk_bad) begin
              ost_r <= ST_BADOP;
            end else if (c0 == CH_G) begin
              await_r <= 1'b1;
              dp_r    <= blk;
              dcnt_r  <= '0;
              ost_r   <= ST_AWAIT;
            end else begin
              blk_r   <= blk;
              k_r     <= '0;
              state_r <= S_PDRD;
            end
          end else if (c0 == CH_H) begin
            open_r <= 1'b0;
            ost_r  <= ST_HALT;
          end else if (is_lscba) begin
            if (addr_bad) begin
              ost_r <= ST_BADOP;
            end else if (c0 == CH_B) begin
              if (tog_r) begin
                pc_r <= addr;
              end
            end else if (c0 != CH_S) begin
              state_r <= S_OPRD;
            end
          end
        end
        S_OPRD: begin
          state_r <= S_OUT;
          if (c0 == CH_L) begin
            gr_r <= rd_q;
          end else if (c0 == CH_C) begin
            tog_r <= (rd_q == gr_r);
          end else begin
            opb_r   <= rd_q;
            psh_r   <= gr_r;
            pi_r    <= 1'b0;
            pcnt_r  <= '0;
            ph_r    <= P_LEAD;
            neg_r   <= 1'b0;
            nd_r    <= 1'b0;
            acc_r   <= '0;
            state_r <= S_PARSE;
          end
        end
        S_PARSE: begin
          unique case (ph_r)
            P_LEAD: begin
              if (p_sp) begin
                ph_r <= P_LEAD;
              end else if (pch == CH_PLUS || pch == CH_MINUS) begin
                neg_r <= (pch == CH_MINUS);
                ph_r  <= P_DIG;
              end else if (p_dig) begin
                acc_r <= acc_mul;
                nd_r  <= 1'b1;
                ph_r  <= P_DIG;
              end else begin
                ph_r <= P_STOP;
              end
            end
            P_DIG: begin
              if (p_dig) begin
                acc_r <= acc_mul;
                nd_r  <= 1'b1;
              end else begin
                ph_r <= P_STOP;
              end
            end
            default: ph_r <= P_STOP;
          endcase
          psh_r  <= {psh_r[23:0], 8'h00};
          pcnt_r <= pcnt_r + 2'd1;
          if (pcnt_r == 2'd3) begin
            state_r <= S_PEND;
          end
        end
        S_PEND: begin
          if (!nd_r) begin
            ost_r   <= ST_BADOP;
            state_r <= S_OUT;
          end else if (!pi_r) begin
            a_r     <= pval;
            psh_r   <= opb_r;
            pi_r    <= 1'b1;
            pcnt_r  <= '0;
            ph_r    <= P_LEAD;
            neg_r   <= 1'b0;
            nd_r    <= 1'b0;
            acc_r   <= '0;
            state_r <= S_PARSE;
          end else begin
            fneg_r  <= psum[15];
            fm_r    <= psum[15] ? 15'(-psum) : psum[14:0];
            nr_r    <= '0;
            state_r <= S_FMT;
          end
        end
        S_FMT: begin
          rev_r[nr_r] <= fdig;
          nr_r        <= nr_r + 3'd1;
          fm_r        <= fq;
          if (fq == '0) begin
            state_r <= S_PACK;
          end
        end
        S_PACK: begin
          gr_r    <= ftext;
          state_r <= S_OUT;
        end
        S_PDRD: begin
          state_r <= S_PDOUT;
        end
        S_PDOUT: begin
          opd_r   <= 1'b1;
          ost_r   <= ST_OUTWORD;
          oword_r <= rd_q;
          omask_r <= pmask;
          olast_r <= (k_r == BLK4 - 4'd1);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            if (opd_r && !olast_r) begin
              k_r     <= k_r + 4'd1;
              state_r <= S_PDRD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result beat
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = ost_r;
  assign out_tlast  = opd_r ? olast_r : 1'b1;
  assign out_tdata  = {5'd0, pc_r, (opd_r ? omask_r : 4'd0), (opd_r ? oword_r : 32'd0)};

  // checks
  `AWM_ASSERT_NOW(a_one_side, out_tvalid, !in_tready, "input taken while a beat is pending")
  `AWM_ASSERT_NOW(a_await_open, await_r, open_r, "data awaited with no open job")
  `AWM_ASSERT_NXT(a_job_reset, in_acc && req == REQ_JOB, open_r && tog_r && pc_r == '0, "job reset did not restart")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ASCII word machine executor testbench
// Drives job reset, load, step and data beats through the input stream,
// predicts every result beat with a behavioral copy of the machine and
// checks each output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import awm_pkg::*;

  localparam int MEMW  = 100;
  localparam int BLKW  = 10;
  localparam int LIMIT = 400000;

  typedef struct packed {
    status_t    st;
    logic [31:0] w;
    logic [3:0]  mask;
    logic        lst;
    logic [6:0]  pc;
  } res_t;

  typedef struct {
    req_t        kind;
    logic [31:0] w;
    logic        dl;
    bit          has_exp;
    status_t     exp_st;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // machine state copy
  logic [31:0] mem [MEMW];
  logic [31:0] acc;
  logic        tog;
  int          ic, lp, dp;
  bit          waiting, open_job;

  res_t   pending_res[$];
  int     errors = 0;
  int     cycles = 0;
  int     n_items = 0;
  bit     calm = 1'b0;

  ascii_word_machine_executor_top #(.MEM_WORDS(MEMW), .BLOCK_WORDS(BLKW)) uut (.*);

  always #5 clk = ~clk;

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] chr(logic [31:0] w, int i);
    return w[31-8*i -: 8];
  endfunction

  function automatic int digit(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : -1;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit parse_dec(logic [31:0] w, output int v);
    int i, n;
    bit neg;
    i = 0; n = 0; neg = 0; v = 0;
    while (i < 4 && is_ws(chr(w, i))) i++;
    if (i < 4 && (chr(w, i) == CH_PLUS || chr(w, i) == CH_MINUS)) begin
      neg = chr(w, i) == CH_MINUS;
      i++;
    end
    while (i < 4 && digit(chr(w, i)) >= 0) begin
      v = v * 10 + digit(chr(w, i));
      i++; n++;
    end
    if (neg) v = -v;
    return n > 0;
  endfunction

  function automatic logic [31:0] dec_text(int v);
    logic [7:0] txt[$];
    logic [7:0] rv[$];
    int m;
    logic [31:0] w;
    if (v < 0) begin
      txt.push_back(CH_MINUS);
      m = -v;
    end else m = v;
    do begin
      rv.push_back(CH_ZERO + 8'(m % 10));
      m /= 10;
    end while (m != 0);
    while (rv.size() > 0) txt.push_back(rv.pop_back());
    w = '0;
    for (int i = 0; i < 4; i++) w = {w[23:0], (i < txt.size()) ? txt[i] : CH_SPACE};
    return w;
  endfunction

  function automatic void push_res(status_t st, logic [31:0] w = '0, logic [3:0] mk = '0,
                                   logic lst = 1'b1);
    pending_res.push_back('{st, w, mk, lst, 7'(ic)});
  endfunction

  function automatic void job_clear();
    foreach (mem[i]) mem[i] = '0;
    acc = '0; tog = 1'b1; ic = 0; lp = 0; dp = 0; waiting = 0; open_job = 0;
  endfunction

  // one instruction step
  function automatic void run_instr();
    logic [31:0] ir;
    logic [7:0]  c0, c1;
    int d2, d3, addr, a, b;
    logic [3:0] mk;
    if (!open_job || waiting) begin
      push_res(ST_REJECT);
      return;
    end
    if (ic >= MEMW - 1 || chr(mem[ic], 0) == CH_NUL) begin
      open_job = 0;
      push_res(ST_END);
      return;
    end
    ir = mem[ic];
    ic++;
    c0 = chr(ir, 0); c1 = chr(ir, 1);
    d2 = digit(chr(ir, 2)); d3 = digit(chr(ir, 3));
    addr = (d2 < 0 || d3 < 0) ? MEMW : d2 * 10 + d3;
    if ((c0 == CH_G || c0 == CH_P) && c1 == CH_D) begin
      if (d2 < 0 || d2 * 10 + BLKW > MEMW) begin
        push_res(ST_BADOP);
      end else if (c0 == CH_G) begin
        waiting = 1; dp = d2 * 10;
        push_res(ST_AWAIT);
      end else begin
        for (int k = 0; k < BLKW; k++) begin
          mk = '0;
          for (int i = 0; i < 4; i++) if (chr(mem[d2*10+k], i) != CH_NUL) mk[3-i] = 1'b1;
          push_res(ST_OUTWORD, mem[d2*10+k], mk, k == BLKW - 1);
        end
      end
      return;
    end
    if (c0 == CH_H) begin
      open_job = 0;
      push_res(ST_HALT);
      return;
    end
    if ((c0 == CH_L && c1 == CH_R) || (c0 == CH_S && c1 == CH_R) || (c0 == CH_C && c1 == CH_R)
        || (c0 == CH_B && c1 == CH_T) || (c0 == CH_A && c1 == CH_D)) begin
      if (addr >= MEMW) begin
        push_res(ST_BADOP);
        return;
      end
      case (c0)
        CH_L: acc = mem[addr];
        CH_S: mem[addr] = acc;
        CH_C: tog = mem[addr] == acc;
        CH_B: if (tog) ic = addr;
        default: begin
          if (!parse_dec(acc, a) || !parse_dec(mem[addr], b)) begin
            push_res(ST_BADOP);
            return;
          end
          acc = dec_text(a + b);
        end
      endcase
    end
    push_res(ST_OK);
  endfunction

  // expected results of one accepted input beat
  function automatic void predict_beat(req_t kind, logic [31:0] w, logic dl);
    logic [31:0] v;
    bit cut;
    case (kind)
      REQ_JOB: begin
        job_clear();
        open_job = 1;
        push_res(ST_OK);
      end
      REQ_LOAD: begin
        if (lp >= MEMW) push_res(ST_REJECT);
        else begin
          cut = 0; v = '0;
          for (int i = 0; i < 4; i++) begin
            v = {v[23:0], cut ? CH_NUL : chr(w, i)};
            if (chr(w, i) == CH_H) cut = 1;
          end
          mem[lp] = v; lp++;
          push_res(ST_OK);
        end
      end
      REQ_DATA: begin
        if (!waiting || dp >= MEMW) begin
          waiting = 0;
          push_res(ST_REJECT);
        end else begin
          mem[dp] = w; dp++;
          if (dl || dp % 10 == BLKW % 10) waiting = 0;
          push_res(ST_OK);
        end
      end
      default: run_instr();
    endcase
  endfunction

  // result beat checker
  always @(posedge clk) begin
    res_t got, ex;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{status_t'(out_tuser), out_tdata[31:0], out_tdata[35:32], out_tlast,
              out_tdata[42:36]};
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $time, got);
      end else begin
        ex = pending_res.pop_front();
        if (got !== ex) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, ex, got);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
      out_tready <= 1'b1;
    end else out_tready <= 1'b1;
  end

  // drive one beat and predict it once accepted
  task automatic send(req_t kind, logic [31:0] w, logic dl);
    int gap;
    n_items++;
    if (n_items > 95) calm = 1'b1;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= w;
    in_tlast  <= dl;
    do @(posedge clk); while (!in_tready);
    predict_beat(kind, w, dl);
    in_tvalid <= 1'b0;
    // the block is busy for at least this cycle after an accepted beat
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] two_dig(int n);
    return {CH_ZERO + 8'(n / 10), CH_ZERO + 8'(n % 10)};
  endfunction

  function automatic logic [31:0] instr(logic [15:0] op, int n);
    return {op, two_dig(n)};
  endfunction

  function automatic logic [31:0] rand_instr();
    int n;
    n = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: return instr({CH_G, CH_D}, $urandom_range(0, 9) * 10);
      1: return instr({CH_P, CH_D}, $urandom_range(0, 9) * 10);
      2: return instr({CH_L, CH_R}, n);
      3: return instr({CH_S, CH_R}, n);
      4: return instr({CH_C, CH_R}, n);
      5: return instr({CH_B, CH_T}, $urandom_range(0, 12));
      6: return instr({CH_A, CH_D}, n);
      7: return {CH_H, 24'($urandom)};
      8: return {CH_A, CH_D, CH_ZERO + 8'($urandom_range(0, 12)), 8'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_num();
    int v;
    logic [31:0] t;
    v = int'($urandom_range(0, 1999)) - 999;
    t = dec_text(v);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {CH_SPACE, t[31:8]};
      default: return t;
    endcase
  endfunction

  stim_t dir_rows[$];

  initial begin
    job_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    dir_rows = '{
      '{REQ_STEP, 32'h0, 1'b0, 1, ST_REJECT},                 // no job open
      '{REQ_DATA, 32'hFFFF_FFFF, 1'b1, 1, ST_REJECT},         // stray data
      '{REQ_JOB,  32'hFFFF_FFFF, 1'b1, 1, ST_OK},
      '{REQ_LOAD, "GD10", 1'b0, 0, ST_OK},
      '{REQ_LOAD, "LR10", 1'b0, 0, ST_OK},
      '{REQ_LOAD, "AD11", 1'b0, 0, ST_OK},
      '{REQ_LOAD, "SR12", 1'b0, 0, ST_OK},
      '{REQ_LOAD, "CR12", 1'b0, 0, ST_OK},
      '{REQ_LOAD, "BT07", 1'b0, 0, ST_OK},
      '{REQ_LOAD, "PD10", 1'b0, 0, ST_OK},
      '{REQ_LOAD, "GDx0", 1'b0, 0, ST_OK},                    // bad operand
      '{REQ_LOAD, "xHAB", 1'b0, 0, ST_OK},                    // H cut in load
      '{REQ_STEP, 32'h0, 1'b0, 1, ST_AWAIT},
      '{REQ_STEP, 32'h0, 1'b0, 1, ST_REJECT},                 // awaiting data
      '{REQ_DATA, " 999", 1'b0, 0, ST_OK},
      '{REQ_DATA, "-5ab", 1'b1, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 1, ST_BADOP},
      '{REQ_STEP, 32'h0, 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 1, ST_END},                    // NUL word
      '{REQ_JOB,  32'h0, 1'b0, 1, ST_OK},
      '{REQ_LOAD, "BT99", 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 0, ST_OK},
      '{REQ_STEP, 32'h0, 1'b0, 1, ST_END}                     // counter at the top
    };
    foreach (dir_rows[i]) begin
      send(dir_rows[i].kind, dir_rows[i].w, dir_rows[i].dl);
      if (dir_rows[i].has_exp && pending_res[$].st !== dir_rows[i].exp_st) begin
        errors++;
        $display("%0t: row %0d expected %s actual %s", $time, i,
                 dir_rows[i].exp_st.name(), pending_res[$].st.name());
      end
    end
    drain();   // sender holds off until every result is back

    // random jobs: well-formed programs with random content, plus noise
    while (n_items < 120) begin
      int plen;
      send(REQ_JOB, $urandom, 1'($urandom_range(0, 1)));
      plen = $urandom_range(3, 10);
      for (int i = 0; i < plen; i++) send(REQ_LOAD, rand_instr(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) send(REQ_LOAD, {CH_H, 24'($urandom)}, 1'b0);
      for (int i = plen + 1; i < 14; i++) send(REQ_LOAD, rand_num(), 1'b0);
      for (int s = 0; s < 25 && n_items < 125; s++) begin
        if (waiting) begin
          int nd;
          nd = $urandom_range(1, 11);
          for (int d = 0; d < nd && waiting; d++)
            send(REQ_DATA, rand_num(), $urandom_range(0, 4) == 0);
        end else if ($urandom_range(0, 15) == 0) begin
          send(REQ_DATA, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          send(REQ_STEP, $urandom, 1'($urandom_range(0, 1)));
        end
        if (!open_job) break;
      end
    end
    calm = 1'b1;
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
